[rtl/core/rcsa_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the reference-counted slot allocator.
// No dependencies; imported by the channel interfaces and the top level.

package rcsa_pkg;

  // Fixed payload widths of the request and response channels
  localparam int SLOT_BITS   = 8;
  localparam int KIND_BITS   = 2;
  localparam int STATUS_BITS = 2;
  localparam int LIVE_BITS   = 9;

  typedef logic [KIND_BITS-1:0]   kind_t;
  typedef logic [STATUS_BITS-1:0] status_t;

  // Request kinds; the fourth code is unknown and answered with a not-live status
  localparam kind_t REQ_ALLOC   = 2'd0;
  localparam kind_t REQ_ADD_REF = 2'd1;
  localparam kind_t REQ_RELEASE = 2'd2;

  // Response status codes
  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_NOT_LIVE  = 2'd1;
  localparam status_t STATUS_NO_FREE   = 2'd2;
  localparam status_t STATUS_SATURATED = 2'd3;

  typedef struct packed {
    kind_t                req_type;
    logic [SLOT_BITS-1:0] slot;
  } req_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0] granted_slot;
    status_t              status;
    logic                 released;
    logic [LIVE_BITS-1:0] live_count;
  } rsp_t;

endpackage

[rtl/core/rcsa_req_if.sv]
`timescale 1ns / 1ps
// Request channel: valid/ready handshake carrying one allocator request.
// Depends on rcsa_pkg for the payload type.

interface rcsa_req_if;
  logic           valid;
  logic           ready;
  rcsa_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/rcsa_rsp_if.sv]
`timescale 1ns / 1ps
// Response channel: valid/ready handshake carrying one allocator result.
// Depends on rcsa_pkg for the payload type.

interface rcsa_rsp_if;
  logic           valid;
  logic           ready;
  rcsa_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/refcounted_slot_allocator.sv]
`timescale 1ns / 1ps
// Reference-counted slot allocator, top level.
// Depends on rcsa_pkg, rcsa_req_if and rcsa_rsp_if.
//
// The allocator takes one request per clock cycle unless stalled (allocate,
// add reference, release reference) and returns exactly one response per
// request, in order: the request is registered while
// the slot's reference count is read from the count memory, then the
// decision is made and the response lands in an output register. Freed slots
// are reused last-in-first-out; the most recently freed slot sits in a head
// register and the rest of the free list in a stack memory whose next entry
// is prefetched every cycle, so back-to-back allocates run at full rate.
// Slot liveness is held in one flip-flop per slot, cleared by reset, so no
// clearing pass is needed after reset. A stalled response holds one request
// in the decision stage; the request side stalls only when both are full.

module refcounted_slot_allocator #(
  parameter int SLOT_COUNT = 256,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  rcsa_req_if.sink    req,
  rcsa_rsp_if.source  rsp
);
  import rcsa_pkg::*;

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int UW = $clog2(SLOT_COUNT + 1);
  localparam int IW = ((SW > SLOT_BITS) ? SW : SLOT_BITS) + 1;
  localparam int CW = COUNT_BITS;
  localparam logic [CW-1:0] COUNT_MAX = '1;

  // Handshake and stage control
  logic e_valid, e_advance, e_fire, accept;
  logic o_valid;
  rsp_t o_data;

  // Decision stage registers
  kind_t                e_kind;
  logic [SLOT_BITS-1:0] e_slot;
  logic [SW-1:0]        e_idx;
  logic                 e_in_range;

  // Request slot mapped onto the slot index space
  logic [IW-1:0] in_wide;
  logic [SW-1:0] in_idx;
  logic          in_range;

  // Reference count memory with one-entry write bypass
  logic [CW-1:0] cnt_mem [SLOT_COUNT];
  logic [CW-1:0] cnt_rd;
  logic          cnt_bp_valid;
  logic [SW-1:0] cnt_bp_addr;
  logic [CW-1:0] cnt_bp_data;
  logic [CW-1:0] cnt_cur;
  logic          cnt_we;
  logic [SW-1:0] cnt_waddr;
  logic [CW-1:0] cnt_wdata;

  // Liveness flags
  logic [SLOT_COUNT-1:0] live_bits;
  logic                  live_cur;
  logic                  live_set, live_clr;
  logic [SW-1:0]         live_addr;

  // Free list: head register plus stack memory below it
  logic [SW-1:0] stk_mem [SLOT_COUNT];
  logic [SW-1:0] stk_rd;
  logic          stk_fwd_hit;
  logic [SW-1:0] stk_fwd_data;
  logic [SW-1:0] stk_top;
  logic [SW-1:0] stk_raddr;
  logic          stk_we;
  logic [SW-1:0] head, head_next;
  logic          head_valid, head_valid_next;
  logic [SW-1:0] depth, depth_next, depth_eff;

  // Occupancy counters
  logic [UW-1:0] created, created_next;
  logic [UW-1:0] in_use, in_use_next;

  // Response fields
  logic [SW-1:0] got;
  rsp_t          rsp_next;

  // Advance when the output register is free or being drained
  assign e_advance = !o_valid || rsp.ready;
  assign req.ready = !e_valid || e_advance;
  assign accept    = req.valid && req.ready;
  assign e_fire    = e_valid && e_advance;

  assign in_wide  = IW'(req.data.slot);
  assign in_idx   = in_wide[SW-1:0];
  assign in_range = in_wide < IW'(SLOT_COUNT);

  // Hold or load the decision stage
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (req.ready) begin
      e_valid <= req.valid;
    end
    if (accept) begin
      e_kind     <= req.data.req_type;
      e_slot     <= req.data.slot;
      e_idx      <= in_idx;
      e_in_range <= in_range;
    end
  end

  // Count memory: read on request transaction, write on decision
  always_ff @(posedge clk) begin
    if (accept) begin
      cnt_rd <= cnt_mem[in_idx];
    end
    if (e_fire && cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
  end

  // Remember the last count write for a read issued at the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_bp_valid <= 1'b0;
    end else if (e_fire && cnt_we) begin
      cnt_bp_valid <= 1'b1;
    end
    if (e_fire && cnt_we) begin
      cnt_bp_addr <= cnt_waddr;
      cnt_bp_data <= cnt_wdata;
    end
  end

  assign cnt_cur  = (cnt_bp_valid && cnt_bp_addr == e_idx) ? cnt_bp_data : cnt_rd;
  assign live_cur = e_in_range && live_bits[e_idx];

  // Prefetch the stack entry under the head for the next cycle's state
  assign depth_eff = e_fire ? depth_next : depth;
  assign stk_raddr = depth_eff - SW'(1);

  always_ff @(posedge clk) begin
    stk_rd <= stk_mem[stk_raddr];
    if (e_fire && stk_we) begin
      stk_mem[depth] <= head;
    end
  end

  // Forward a push that lands on the prefetched address
  always_ff @(posedge clk) begin
    if (rst) begin
      stk_fwd_hit <= 1'b0;
    end else begin
      stk_fwd_hit <= e_fire && stk_we && (depth == stk_raddr);
    end
    stk_fwd_data <= head;
  end

  assign stk_top = stk_fwd_hit ? stk_fwd_data : stk_rd;

  // Decide the request and compute the next allocator state
  always_comb begin
    head_next       = head;
    head_valid_next = head_valid;
    depth_next      = depth;
    created_next    = created;
    in_use_next     = in_use;
    live_set        = 1'b0;
    live_clr        = 1'b0;
    live_addr       = e_idx;
    cnt_we          = 1'b0;
    cnt_waddr       = e_idx;
    cnt_wdata       = cnt_cur;
    stk_we          = 1'b0;
    got             = e_idx;
    rsp_next.granted_slot = e_slot;
    rsp_next.status       = STATUS_OK;
    rsp_next.released     = 1'b0;

    unique case (e_kind)
      REQ_ALLOC: begin
        if (head_valid) begin
          // Pop the most recently freed slot
          got = head;
          if (depth != '0) begin
            head_next  = stk_top;
            depth_next = depth - SW'(1);
          end else begin
            head_valid_next = 1'b0;
          end
        end else if (created < UW'(SLOT_COUNT)) begin
          // Create a fresh slot
          got          = created[SW-1:0];
          created_next = created + UW'(1);
        end else begin
          rsp_next.status = STATUS_NO_FREE;
        end
        if (rsp_next.status == STATUS_OK) begin
          live_set    = 1'b1;
          live_addr   = got;
          cnt_we      = 1'b1;
          cnt_waddr   = got;
          cnt_wdata   = CW'(1);
          in_use_next = in_use + UW'(1);
          rsp_next.granted_slot = SLOT_BITS'(got);
        end else begin
          rsp_next.granted_slot = '0;
        end
      end
      REQ_ADD_REF: begin
        if (!live_cur) begin
          rsp_next.status = STATUS_NOT_LIVE;
        end else if (cnt_cur == COUNT_MAX) begin
          rsp_next.status = STATUS_SATURATED;
        end else begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_cur + CW'(1);
        end
      end
      REQ_RELEASE: begin
        if (!live_cur) begin
          rsp_next.status = STATUS_NOT_LIVE;
        end else if (cnt_cur > CW'(1)) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_cur - CW'(1);
        end else begin
          // Drop to zero and push the slot onto the free list
          cnt_we    = 1'b1;
          cnt_wdata = '0;
          live_clr  = 1'b1;
          if (head_valid) begin
            stk_we     = 1'b1;
            depth_next = depth + SW'(1);
          end
          head_next       = e_idx;
          head_valid_next = 1'b1;
          if (in_use != '0) begin
            in_use_next = in_use - UW'(1);
          end
          rsp_next.released = 1'b1;
        end
      end
      default: begin
        rsp_next.status = STATUS_NOT_LIVE;
      end
    endcase

    rsp_next.live_count = LIVE_BITS'(in_use_next);
  end

  // Update allocator state on each decided request
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      depth      <= '0;
      created    <= '0;
      in_use     <= '0;
      live_bits  <= '0;
    end else if (e_fire) begin
      head_valid <= head_valid_next;
      depth      <= depth_next;
      created    <= created_next;
      in_use     <= in_use_next;
      if (live_set) begin
        live_bits[live_addr] <= 1'b1;
      end
      if (live_clr) begin
        live_bits[e_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e_fire) begin
      head <= head_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (e_advance) begin
      o_valid <= e_valid;
    end
    if (e_fire) begin
      o_data <= rsp_next;
    end
  end

  assign rsp.valid = o_valid;
  assign rsp.data  = o_data;

endmodule

[bench/tb_refcounted_slot_allocator.sv]
`timescale 1ns / 1ps
// Self-checking testbench for refcounted_slot_allocator: directed and random
// requests checked against an in-bench model. Depends on rcsa_pkg and the channel interfaces.

module tb_refcounted_slot_allocator;
  import rcsa_pkg::*;

  localparam int SLOTS       = 256;
  localparam int COUNT_WIDTH = 16;
  localparam logic [8:0] NO_SLOT = 9'(SLOTS);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam kind_t REQ_UNKNOWN = 2'd3;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int REPORT_LIMIT = 10;

  logic clk = 1'b0;
  logic rst;

  rcsa_req_if req ();
  rcsa_rsp_if rsp ();

  refcounted_slot_allocator #(
    .SLOT_COUNT(SLOTS),
    .COUNT_BITS(COUNT_WIDTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #4 clk = ~clk;

  // Allocator model state
  logic [8:0]             slot_link [SLOTS];
  logic [COUNT_WIDTH-1:0] slot_refs [SLOTS];
  logic [8:0]             free_top;
  logic [8:0]             free_bottom;
  logic [8:0]             slots_made;
  logic [8:0]             slots_busy;

  rsp_t awaited_responses[$];
  rsp_t last_outcome;
  int   error_count = 0;
  int   cycle_count = 0;

  // Idling controls, written only by the test sequence
  bit sender_idles_on   = 1'b0;
  bit receiver_stalls_on = 1'b0;
  int hold_off_asks = 0;
  int hold_off_len  = 0;

  function automatic bit slot_is_live(logic [7:0] s);
    return ({1'b0, s} < slots_made) && (slot_link[s] == NO_SLOT) &&
           ({1'b0, s} != free_bottom);
  endfunction

  // Apply one request to the model and return the response it must produce
  function automatic rsp_t allocator_outcome(kind_t kind, logic [7:0] s);
    rsp_t       o;
    logic [8:0] got;
    o.granted_slot = s;
    o.status       = STATUS_OK;
    o.released     = 1'b0;
    case (kind)
      REQ_ALLOC: begin
        got = NO_SLOT;
        if (free_top < NO_SLOT) begin
          got = free_top;
          free_top = slot_link[got[7:0]];
          slot_link[got[7:0]] = NO_SLOT;
          if (free_bottom == got) free_bottom = NO_SLOT;
        end else if (slots_made < NO_SLOT) begin
          got = slots_made;
          slot_link[got[7:0]] = NO_SLOT;
          slots_made = slots_made + 9'd1;
        end
        if (got < NO_SLOT) begin
          slot_refs[got[7:0]] = COUNT_WIDTH'(1);
          slots_busy = slots_busy + 9'd1;
          o.granted_slot = got[7:0];
        end else begin
          o.granted_slot = '0;
          o.status = STATUS_NO_FREE;
        end
      end
      REQ_ADD_REF: begin
        if (!slot_is_live(s)) o.status = STATUS_NOT_LIVE;
        else if (slot_refs[s] == COUNT_MAX) o.status = STATUS_SATURATED;
        else slot_refs[s] = slot_refs[s] + 1'b1;
      end
      REQ_RELEASE: begin
        if (!slot_is_live(s)) begin
          o.status = STATUS_NOT_LIVE;
        end else if (slot_refs[s] > 1) begin
          slot_refs[s] = slot_refs[s] - 1'b1;
        end else begin
          slot_refs[s] = '0;
          slot_link[s] = free_top;
          free_top = {1'b0, s};
          if (free_bottom == NO_SLOT) free_bottom = {1'b0, s};
          if (slots_busy > 0) slots_busy = slots_busy - 9'd1;
          o.released = 1'b1;
        end
      end
      default: o.status = STATUS_NOT_LIVE;
    endcase
    o.live_count = slots_busy;
    return o;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request, hold it until accepted, then record the response it must produce
  task automatic send_req(kind_t kind, logic [7:0] s);
    req_t item;
    int   gap;
    gap = 0;
    if (sender_idles_on && $urandom_range(0, 1) == 0) gap = random_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.req_type = kind;
    item.slot     = s;
    req.valid <= 1'b1;
    req.data  <= item;
    do @(posedge clk); while (!req.ready);
    last_outcome = allocator_outcome(kind, s);
    awaited_responses.insert(awaited_responses.size(), last_outcome);
  endtask

  // Stop offering and wait for every outstanding transaction to come back
  task automatic drain_responses();
    req.valid <= 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Prefer a live slot so most traffic reaches past the liveness check
  function automatic logic [7:0] pick_live_slot();
    logic [7:0] s;
    if (slots_busy != 0) begin
      repeat (16) begin
        s = 8'($urandom_range(0, int'(slots_made) - 1));
        if (slot_is_live(s)) return s;
      end
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_request(int alloc_weight);
    int r;
    r = $urandom_range(0, 99);
    if (r < alloc_weight)
      send_req(REQ_ALLOC, 8'($urandom_range(0, 255)));
    else if (r < 94)
      send_req(($urandom_range(0, 99) < 55) ? REQ_RELEASE : REQ_ADD_REF, pick_live_slot());
    else if (r < 98)
      send_req(($urandom_range(0, 1) != 0) ? REQ_RELEASE : REQ_ADD_REF,
               8'($urandom_range(0, 255)));
    else
      send_req(REQ_UNKNOWN, 8'($urandom_range(0, 255)));
  endtask

  // Release a live slot until it returns to the free list
  task automatic release_fully(logic [7:0] s);
    do send_req(REQ_RELEASE, s);
    while (last_outcome.status == STATUS_OK && !last_outcome.released);
  endtask

  task automatic record_failure(string what);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("[%0t] %s", $realtime, what);
  endtask

  // Receiver: random stalls plus requested long hold-offs
  always @(posedge clk) begin : drive_rsp_ready
    static int stall_left = 0;
    static int hold_served = 0;
    if (hold_served != hold_off_asks) begin
      hold_served = hold_off_asks;
      stall_left  = hold_off_len;
    end
    if (stall_left > 0) begin
      stall_left--;
      rsp.ready <= 1'b0;
    end else if (receiver_stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left = random_gap() - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Compare each response transaction with the oldest prediction
  always @(posedge clk) begin : check_responses
    rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (awaited_responses.size() == 0) begin
        record_failure($sformatf("unexpected response %p", rsp.data));
      end else begin
        want = awaited_responses.pop_front();
        if (rsp.data.granted_slot !== want.granted_slot || rsp.data.status !== want.status ||
            rsp.data.released !== want.released || rsp.data.live_count !== want.live_count)
          record_failure($sformatf(
            {"mismatch: slot exp %0d got %0d, status exp %0d got %0d, ",
             "released exp %0d got %0d, live exp %0d got %0d"},
            want.granted_slot, rsp.data.granted_slot, want.status, rsp.data.status,
            want.released, rsp.data.released, want.live_count, rsp.data.live_count));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Requests on an empty allocator and unknown kinds
  task automatic test_idle_requests();
    send_req(REQ_ADD_REF, 8'h00);
    send_req(REQ_RELEASE, 8'hFF);
    send_req(REQ_UNKNOWN, 8'hAA);
    send_req(REQ_RELEASE, 8'h00);
    drain_responses();
  endtask

  // Basic allocate, reference, release and LIFO reuse
  task automatic test_basic_lifecycle();
    send_req(REQ_ALLOC, 8'hFF);
    send_req(REQ_ALLOC, 8'h00);
    send_req(REQ_ADD_REF, 8'h00);
    send_req(REQ_ADD_REF, 8'h02);
    send_req(REQ_RELEASE, 8'h00);
    send_req(REQ_RELEASE, 8'h00);
    send_req(REQ_RELEASE, 8'h00);
    send_req(REQ_ADD_REF, 8'h00);
    send_req(REQ_ALLOC, 8'h55);
    send_req(REQ_RELEASE, 8'h01);
    send_req(REQ_RELEASE, 8'h00);
    send_req(REQ_RELEASE, 8'h01);
    send_req(REQ_ALLOC, 8'hAA);
    send_req(REQ_ALLOC, 8'h00);
    send_req(REQ_ALLOC, 8'h00);
    send_req(REQ_UNKNOWN, 8'h55);
    send_req(REQ_ADD_REF, 8'hFF);
    drain_responses();
  endtask

  // Fill every slot, hit the empty-pool case, free in shuffled order, reuse half
  task automatic test_exhaust_slots();
    int order[SLOTS];
    int j;
    int t;
    while (slots_busy < NO_SLOT) send_req(REQ_ALLOC, 8'($urandom_range(0, 255)));
    send_req(REQ_ALLOC, 8'h00);
    send_req(REQ_ALLOC, 8'hFF);
    send_req(REQ_ADD_REF, 8'hFF);
    for (int i = 0; i < SLOTS; i++) order[i] = i;
    for (int i = SLOTS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    foreach (order[i]) release_fully(8'(order[i]));
    send_req(REQ_RELEASE, 8'(order[SLOTS-1]));
    send_req(REQ_ADD_REF, 8'(order[0]));
    repeat (SLOTS / 2) send_req(REQ_ALLOC, 8'h00);
    drain_responses();
  endtask

  // Raise one slot's count well above one and walk it back down to zero
  task automatic test_count_walk();
    logic [7:0] s;
    send_req(REQ_ALLOC, 8'h00);
    s = last_outcome.granted_slot;
    repeat (20) send_req(REQ_ADD_REF, s);
    release_fully(s);
    drain_responses();
  endtask

  // Long receiver hold-off while the sender keeps offering
  task automatic test_input_stall();
    hold_off_len  = 300;
    hold_off_asks = hold_off_asks + 1;
    repeat (40) random_request(40);
    drain_responses();
  endtask

  task automatic test_random_traffic();
    for (int burst = 0; burst < 11; burst++) begin
      sender_idles_on    = ($urandom_range(0, 2) != 0);
      receiver_stalls_on = ($urandom_range(0, 2) != 0);
      repeat (36) random_request((burst % 2 == 0) ? 55 : 15);
      if (burst == 5) drain_responses();
    end
    drain_responses();
  endtask

  initial begin
    rst       = 1'b1;
    req.valid = 1'b0;
    req.data  = '0;
    slot_link = '{default: '0};
    slot_refs = '{default: '0};
    free_top    = NO_SLOT;
    free_bottom = NO_SLOT;
    slots_made  = '0;
    slots_busy  = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    sender_idles_on    = 1'b1;
    receiver_stalls_on = 1'b1;
    test_idle_requests();
    test_basic_lifecycle();
    test_exhaust_slots();
    sender_idles_on    = 1'b0;
    receiver_stalls_on = 1'b0;
    test_count_walk();
    test_input_stall();
    test_random_traffic();

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/rcsa_pkg.sv
rtl/core/rcsa_req_if.sv
rtl/core/rcsa_rsp_if.sv
rtl/core/refcounted_slot_allocator.sv
bench/tb_refcounted_slot_allocator.sv
